[rtl/dltp_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dltp_pkg: shared types and constants of the delta list timer pool
// Field widths, operation and status codes, and the command and status
// bundles between the controller and the datapath.
// -----------------------------------------------------------------------------
package dltp_pkg;

   localparam int MODE_W = 3;
   localparam int KEY_W  = 16;
   localparam int PER_W  = 32;
   localparam int ST_W   = 3;

   // most expiries reported by one poll
   localparam int MAX_OUT    = 16;
   localparam int POLL_CNT_W = $clog2(MAX_OUT);

   // request operations
   localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POLL    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_ARG   = 3'd1,
      ST_EXISTS    = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   // micro operations issued by the controller
   typedef struct packed {
      logic       load;
      logic       cr_scan;
      logic       cr_alloc;
      logic       arm_step;
      logic       rscan;
      logic       ascan;
      logic       del_fix;
      logic       tick_dec;
      logic       tick_move;
      logic       head_load;
      logic       pop;
      logic       clear;
      logic       emit;
      logic       emit_fired;
      logic       emit_last;
      status_type emit_st;
   } cmd_type;

   // conditions reported by the datapath
   typedef struct packed {
      logic per_zero;
      logic scan_last;
      logic dup;
      logic free_found;
      logic arm_ins;
      logic rhit;
      logic rend;
      logic ahit;
      logic aend;
      logic front_zero;
      logic head_zero;
      logic act_empty;
      logic rc_zero;
      logic cur_rep;
      logic out_free;
   } stat_type;

endpackage

[rtl/dltp_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dltp_if: request and response channels of the timer pool
// Valid/ready channels; a transfer happens when valid and ready are both high.
// -----------------------------------------------------------------------------
interface dltp_req_if;
   logic                         valid;
   logic                         ready;
   logic [dltp_pkg::MODE_W-1:0]  mode;
   logic [dltp_pkg::KEY_W-1:0]   key;
   logic [dltp_pkg::PER_W-1:0]   period;
   logic                         repeat_req;

   modport source (output valid, mode, key, period, repeat_req, input ready);
   modport sink   (input valid, mode, key, period, repeat_req, output ready);
endinterface

interface dltp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dltp_pkg::ST_W-1:0]    status;
   logic [dltp_pkg::KEY_W-1:0]   fired_key;
   logic                         fired_valid;
   logic                         last;

   modport source (output valid, status, fired_key, fired_valid, last, input ready);
   modport sink   (input valid, status, fired_key, fired_valid, last, output ready);
endinterface

[rtl/dltp_datapath.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dltp_datapath: timer slot storage, delta list, ready queue and response
// Executes one controller micro operation per cycle and reports conditions.
// -----------------------------------------------------------------------------
module dltp_datapath #(
   parameter int SLOTS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dltp_pkg::cmd_type           cmd,
   output dltp_pkg::stat_type          stat,
   input  logic [dltp_pkg::KEY_W-1:0]  req_key,
   input  logic [dltp_pkg::PER_W-1:0]  req_period,
   input  logic                        req_repeat,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [dltp_pkg::ST_W-1:0]   rsp_status,
   output logic [dltp_pkg::KEY_W-1:0]  rsp_fired_key,
   output logic                        rsp_fired_valid,
   output logic                        rsp_last
);
   import dltp_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   localparam logic [1:0] WHERE_IDLE   = 2'd0;
   localparam logic [1:0] WHERE_ACTIVE = 2'd1;
   localparam logic [1:0] WHERE_READY  = 2'd2;

   // slot storage
   logic [KEY_W-1:0] key_ff    [SLOTS];
   logic             rep_ff    [SLOTS];
   logic [PER_W-1:0] period_ff [SLOTS];
   logic [PER_W-1:0] delta_ff  [SLOTS];
   logic [1:0]       where_ff  [SLOTS];
   logic [IW-1:0]    order_ff  [SLOTS];
   logic [IW-1:0]    fifo_ff   [SLOTS];

   logic [CW-1:0]    act_cnt_ff, rc_ff, idx_ff;
   logic [PER_W-1:0] head_ff, per_ff, prev_ff, dd_ff;
   logic [KEY_W-1:0] in_key_ff, fkey_ff;
   logic             in_rep_ff, rep_cur_ff, dup_ff, found_ff;
   logic [IW-1:0]    cur_ff, free_ff;

   logic [IW-1:0]    idx_s, ord_i, fifo_i, o0, f0, succ;
   logic [CW-1:0]    idx_p1;
   logic             at_end, idx_zero, arm_ins, r_end, rhit, ahit, succ_ok;
   logic             s_idle, s_hit;
   logic [PER_W-1:0] d_eff, newd, succ_sum;
   logic [PER_W:0]   sum;
   logic [IW-1:0]    order_up [SLOTS];
   logic [IW-1:0]    order_dn [SLOTS];
   logic [IW-1:0]    fifo_dn  [SLOTS];

   // current list position and walk arithmetic
   always_comb begin
      idx_s    = idx_ff[IW-1:0];
      ord_i    = order_ff[idx_s];
      fifo_i   = fifo_ff[idx_s];
      o0       = order_ff[0];
      f0       = fifo_ff[0];
      at_end   = (idx_ff == act_cnt_ff);
      idx_zero = (idx_ff == '0);
      d_eff    = idx_zero ? head_ff : delta_ff[ord_i];
      sum      = {1'b0, prev_ff} + {1'b0, d_eff};
      arm_ins  = at_end || (sum > {1'b0, per_ff});
      newd     = per_ff - prev_ff;
      r_end    = (idx_ff >= rc_ff);
      rhit     = !r_end && (key_ff[fifo_i] == in_key_ff);
      ahit     = !at_end && (key_ff[ord_i] == in_key_ff);
      idx_p1   = idx_ff + CW'(1);
      succ_ok  = (idx_p1 < act_cnt_ff);
      succ     = order_ff[idx_p1[IW-1:0]];
      succ_sum = delta_ff[succ] + dd_ff;
      s_idle   = (where_ff[idx_s] == WHERE_IDLE);
      s_hit    = !s_idle && (key_ff[idx_s] == in_key_ff);
   end

   // neighbor views for list and queue shifts
   always_comb begin
      order_up[0] = order_ff[0];
      for (int j = 1; j < SLOTS; j++) order_up[j] = order_ff[j-1];
      for (int j = 0; j < SLOTS - 1; j++) begin
         order_dn[j] = order_ff[j+1];
         fifo_dn[j]  = fifo_ff[j+1];
      end
      order_dn[SLOTS-1] = order_ff[SLOTS-1];
      fifo_dn[SLOTS-1]  = fifo_ff[SLOTS-1];
   end

   // status toward the controller
   always_comb begin
      stat.per_zero   = (per_ff == '0);
      stat.scan_last  = (idx_ff == CW'(SLOTS - 1));
      stat.dup        = dup_ff;
      stat.free_found = found_ff;
      stat.arm_ins    = arm_ins;
      stat.rhit       = rhit;
      stat.rend       = r_end;
      stat.ahit       = ahit;
      stat.aend       = at_end;
      stat.front_zero = (act_cnt_ff != '0) && (delta_ff[o0] == '0);
      stat.head_zero  = (head_ff == '0);
      stat.act_empty  = (act_cnt_ff == '0);
      stat.rc_zero    = (rc_ff == '0);
      stat.cur_rep    = rep_cur_ff;
      stat.out_free   = !rsp_valid || rsp_ready;
   end

   // request latch, walk index and scratch registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_key_ff <= req_key;
         per_ff    <= req_period;
         in_rep_ff <= req_repeat;
         idx_ff    <= '0;
         dup_ff    <= 1'b0;
         found_ff  <= 1'b0;
      end
      if (cmd.cr_scan) begin
         idx_ff <= idx_ff + CW'(1);
         if (s_hit) dup_ff <= 1'b1;
         if (s_idle && !found_ff) begin
            free_ff  <= idx_s;
            found_ff <= 1'b1;
         end
      end
      if (cmd.cr_alloc) begin
         cur_ff  <= free_ff;
         idx_ff  <= '0;
         prev_ff <= '0;
      end
      if (cmd.arm_step && !arm_ins) begin
         idx_ff  <= idx_ff + CW'(1);
         prev_ff <= sum[PER_W-1:0];
      end
      if (cmd.rscan) begin
         if (r_end) idx_ff <= '0;
         else if (!rhit) idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.ascan) begin
         if (ahit) begin
            cur_ff <= ord_i;
            dd_ff  <= d_eff;
         end else if (!at_end) begin
            idx_ff <= idx_ff + CW'(1);
         end
      end
      if (cmd.pop) begin
         cur_ff     <= f0;
         fkey_ff    <= key_ff[f0];
         per_ff     <= period_ff[f0];
         rep_cur_ff <= rep_ff[f0];
         idx_ff     <= '0;
         prev_ff    <= '0;
      end
   end

   // slot fields, deltas, list order and ready queue
   always_ff @(posedge clock) begin
      if (cmd.cr_alloc) begin
         key_ff[free_ff]    <= in_key_ff;
         rep_ff[free_ff]    <= in_rep_ff;
         period_ff[free_ff] <= per_ff;
      end
      if (cmd.arm_step && arm_ins) begin
         delta_ff[cur_ff] <= newd;
         if (!at_end) delta_ff[ord_i] <= d_eff - newd;
         for (int j = 0; j < SLOTS; j++) begin
            if (CW'(j) == idx_ff) order_ff[j] <= cur_ff;
            else if (CW'(j) > idx_ff) order_ff[j] <= order_up[j];
         end
      end
      if (cmd.del_fix) begin
         if (succ_ok) delta_ff[succ] <= succ_sum;
         for (int j = 0; j < SLOTS; j++) begin
            if (CW'(j) >= idx_ff) order_ff[j] <= order_dn[j];
         end
      end
      if (cmd.tick_move) begin
         for (int j = 0; j < SLOTS; j++) order_ff[j] <= order_dn[j];
         if (rc_ff < CW'(SLOTS)) fifo_ff[rc_ff[IW-1:0]] <= o0;
      end
      if (cmd.rscan && rhit) begin
         for (int j = 0; j < SLOTS; j++) begin
            if (CW'(j) >= idx_ff) fifo_ff[j] <= fifo_dn[j];
         end
      end
      if (cmd.pop) begin
         for (int j = 0; j < SLOTS; j++) fifo_ff[j] <= fifo_dn[j];
      end
   end

   // slot placement
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int j = 0; j < SLOTS; j++) where_ff[j] <= WHERE_IDLE;
      end else begin
         if (cmd.arm_step && arm_ins) where_ff[cur_ff] <= WHERE_ACTIVE;
         if (cmd.rscan && rhit) where_ff[fifo_i] <= WHERE_IDLE;
         if (cmd.del_fix) where_ff[cur_ff] <= WHERE_IDLE;
         if (cmd.tick_move) where_ff[o0] <= WHERE_READY;
         if (cmd.pop && !rep_ff[f0]) where_ff[f0] <= WHERE_IDLE;
      end
   end

   // list count, queue count and head counter
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         act_cnt_ff <= '0;
         rc_ff      <= '0;
         head_ff    <= '0;
      end else begin
         if (cmd.arm_step && arm_ins) begin
            act_cnt_ff <= act_cnt_ff + CW'(1);
            if (idx_zero) head_ff <= newd;
         end
         if (cmd.del_fix) begin
            act_cnt_ff <= act_cnt_ff - CW'(1);
            if (succ_ok && idx_zero) head_ff <= succ_sum;
            else if (!succ_ok && idx_zero) head_ff <= '0;
         end
         if (cmd.tick_dec) head_ff <= head_ff - PER_W'(1);
         if (cmd.tick_move) begin
            act_cnt_ff <= act_cnt_ff - CW'(1);
            if (rc_ff < CW'(SLOTS)) rc_ff <= rc_ff + CW'(1);
         end
         if (cmd.head_load && (act_cnt_ff != '0)) head_ff <= delta_ff[o0];
         if ((cmd.rscan && rhit) || cmd.pop) rc_ff <= rc_ff - CW'(1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status      <= cmd.emit_st;
         rsp_fired_key   <= cmd.emit_fired ? fkey_ff : '0;
         rsp_fired_valid <= cmd.emit_fired;
         rsp_last        <= cmd.emit_last;
      end
   end

endmodule

[rtl/dltp_ctrl.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// dltp_ctrl: operation sequencer of the timer pool
// Accepts one request at a time and steps the datapath through the scans,
// list walks and queue moves of each operation.
// -----------------------------------------------------------------------------
module dltp_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [dltp_pkg::MODE_W-1:0]  req_mode,
   output logic                         req_ready,
   output dltp_pkg::cmd_type            cmd,
   input  dltp_pkg::stat_type           stat
);
   import dltp_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_CR_SCAN, S_CR_DEC, S_ARM, S_DEL_R, S_DEL_A, S_DEL_FIX,
      S_TICK, S_TICK_CHK, S_TICK_MOVE, S_TICK_NEXT, S_POLL_CHK, S_POLL_POP,
      S_POLL_EMIT, S_POLL_NEXT, S_CLEAR, S_EMIT
   } state_type;

   state_type              state_ff;
   status_type             st_ff;
   logic [POLL_CNT_W-1:0]  n_ff;
   logic                   last_ff, ret_poll_ff;
   logic                   poll_last;

   assign req_ready = (state_ff == S_IDLE);
   assign poll_last = stat.rc_zero || (n_ff == POLL_CNT_W'(MAX_OUT - 1));

   // command decode
   always_comb begin
      cmd         = '0;
      cmd.emit_st = ST_OK;
      cmd.load    = req_ready && req_valid;
      case (state_ff)
         S_CR_SCAN:   cmd.cr_scan = 1'b1;
         S_CR_DEC:    cmd.cr_alloc = !stat.per_zero && !stat.dup && stat.free_found;
         S_ARM:       cmd.arm_step = 1'b1;
         S_DEL_R:     cmd.rscan = 1'b1;
         S_DEL_A:     cmd.ascan = 1'b1;
         S_DEL_FIX:   cmd.del_fix = 1'b1;
         S_TICK:      cmd.tick_dec = 1'b1;
         S_TICK_MOVE: cmd.tick_move = 1'b1;
         S_TICK_NEXT: begin
            cmd.tick_move = stat.front_zero;
            cmd.head_load = !stat.front_zero;
         end
         S_POLL_POP:  cmd.pop = 1'b1;
         S_POLL_EMIT: begin
            cmd.emit       = stat.out_free;
            cmd.emit_fired = 1'b1;
            cmd.emit_last  = poll_last;
         end
         S_CLEAR:     cmd.clear = 1'b1;
         S_EMIT: begin
            cmd.emit      = stat.out_free;
            cmd.emit_last = 1'b1;
            cmd.emit_st   = st_ff;
         end
         default: ;
      endcase
   end

   // state and sequencing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         st_ff       <= ST_OK;
         n_ff        <= '0;
         last_ff     <= 1'b0;
         ret_poll_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  n_ff        <= '0;
                  st_ff       <= ST_OK;
                  ret_poll_ff <= 1'b0;
                  case (req_mode)
                     MODE_CREATE:  state_ff <= S_CR_SCAN;
                     MODE_DESTROY: state_ff <= S_DEL_R;
                     MODE_TICK:    state_ff <= S_TICK;
                     MODE_POLL:    state_ff <= S_POLL_CHK;
                     MODE_CLEAR:   state_ff <= S_CLEAR;
                     default: begin
                        st_ff    <= ST_BAD_ARG;
                        state_ff <= S_EMIT;
                     end
                  endcase
               end
            end
            S_CR_SCAN: begin
               if (stat.scan_last) state_ff <= S_CR_DEC;
            end
            S_CR_DEC: begin
               if (stat.per_zero) begin
                  st_ff    <= ST_BAD_ARG;
                  state_ff <= S_EMIT;
               end else if (stat.dup) begin
                  st_ff    <= ST_EXISTS;
                  state_ff <= S_EMIT;
               end else if (!stat.free_found) begin
                  st_ff    <= ST_FULL;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_ARM;
               end
            end
            S_ARM: begin
               if (stat.arm_ins) state_ff <= ret_poll_ff ? S_POLL_NEXT : S_EMIT;
            end
            S_DEL_R: begin
               if (stat.rhit) state_ff <= S_EMIT;
               else if (stat.rend) state_ff <= S_DEL_A;
            end
            S_DEL_A: begin
               if (stat.ahit) begin
                  state_ff <= S_DEL_FIX;
               end else if (stat.aend) begin
                  st_ff    <= ST_NOT_FOUND;
                  state_ff <= S_EMIT;
               end
            end
            S_DEL_FIX: state_ff <= S_EMIT;
            S_TICK:    state_ff <= S_TICK_CHK;
            S_TICK_CHK: begin
               if (stat.head_zero && !stat.act_empty) state_ff <= S_TICK_MOVE;
               else state_ff <= S_EMIT;
            end
            S_TICK_MOVE: state_ff <= S_TICK_NEXT;
            S_TICK_NEXT: begin
               if (!stat.front_zero) state_ff <= S_EMIT;
            end
            S_POLL_CHK: state_ff <= stat.rc_zero ? S_EMIT : S_POLL_POP;
            S_POLL_POP: state_ff <= S_POLL_EMIT;
            S_POLL_EMIT: begin
               if (stat.out_free) begin
                  last_ff <= poll_last;
                  n_ff    <= n_ff + POLL_CNT_W'(1);
                  if (stat.cur_rep) begin
                     ret_poll_ff <= 1'b1;
                     state_ff    <= S_ARM;
                  end else begin
                     state_ff <= S_POLL_NEXT;
                  end
               end
            end
            S_POLL_NEXT: state_ff <= last_ff ? S_IDLE : S_POLL_POP;
            S_CLEAR:     state_ff <= S_EMIT;
            S_EMIT: begin
               if (stat.out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/delta_list_timer_pool_core.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// delta_list_timer_pool_core: keyed software timer pool on a delta list
// Top level joining the operation sequencer and the timer datapath.
// -----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request: create, destroy, tick, poll or clear, with
//   a key, a period and a repeat flag. rsp_chan returns the responses; every
//   request gives one response, except a poll with ready timers, which gives
//   one response per expired timer (at most 16), the final one flagged last.
//   Requests are handled one at a time; req_chan.ready is high only while the
//   sequencer is idle.
//   Create scans every slot, then walks the active list to insert the timer;
//   destroy scans the ready queue, then the active list; tick decrements the
//   head counter and moves each expired timer to the ready queue; poll pops
//   each ready timer and walks the list again for each repeating one. The
//   list walk advances one entry per cycle.
//   Responses leave through an output register; a stalled receiver holds the
//   sequencer at its next response, and the last response may wait there
//   while the next request is already taken.
//   Reset is synchronous and leaves all slots free, both lists empty and the
//   head counter at zero; it needs no clearing pass.
// -----------------------------------------------------------------------------
module delta_list_timer_pool_core #(
   parameter int SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   dltp_req_if.sink   req_chan,
   dltp_rsp_if.source rsp_chan
);
   import dltp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // operation sequencer
   dltp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // timer storage and response register
   dltp_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_key         (req_chan.key),
      .req_period      (req_chan.period),
      .req_repeat      (req_chan.repeat_req),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_fired_key   (rsp_chan.fired_key),
      .rsp_fired_valid (rsp_chan.fired_valid),
      .rsp_last        (rsp_chan.last)
   );

`ifndef SYNTHESIS
   // a response is only loaded when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("response loaded over a pending response");

   // the sequencer is busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request taken back to back");

   // the ready queue is never popped while empty
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.rc_zero)
      else $error("pop from empty ready queue");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb: self-checking bench for the delta list timer pool
// A queue of requests feeds a clocked driver that sends in random bursts; a
// clocked monitor checks every response against a predictor of the pool that
// keeps its own slots, active list, ready queue and head counter.
// -----------------------------------------------------------------------------
module tb;
   import dltp_pkg::*;

   localparam int NSLOT     = 16;
   localparam int WDOG_MAX  = 20000;
   localparam logic [1:0] W_IDLE   = 2'd0;
   localparam logic [1:0] W_ACTIVE = 2'd1;
   localparam logic [1:0] W_READY  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
      logic [PER_W-1:0]  period;
      logic              rep;
   } request_t;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [KEY_W-1:0] fired_key;
      logic             fired_valid;
      logic             last;
   } response_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dltp_req_if req_chan ();
   dltp_rsp_if rsp_chan ();

   delta_list_timer_pool_core #(.SLOTS(NSLOT)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pool model state
   logic [KEY_W-1:0] m_key    [NSLOT];
   logic             m_rep    [NSLOT];
   logic [PER_W-1:0] m_period [NSLOT];
   logic [PER_W-1:0] m_delta  [NSLOT];
   logic [1:0]       m_where  [NSLOT];
   int               m_active [$];
   int               m_ready  [$];
   logic [PER_W-1:0] m_head;

   request_t  pending_reqs [$];
   response_t expected_rsps [$];
   int errors, n_sent, n_rsp, n_fired, n_stat [8];

   function automatic void pool_reset();
      for (int s = 0; s < NSLOT; s++) begin
         m_key[s] = '0; m_rep[s] = 1'b0; m_period[s] = '0;
         m_delta[s] = '0; m_where[s] = W_IDLE;
      end
      m_active.delete();
      m_ready.delete();
      m_head = '0;
   endfunction

   function automatic void free_slot(int s);
      m_key[s] = '0; m_rep[s] = 1'b0; m_period[s] = '0;
      m_delta[s] = '0; m_where[s] = W_IDLE;
   endfunction

   // insert slot into the delta list by its period
   function automatic void arm_slot(int s);
      logic [63:0] total;
      int pos;
      total = 0;
      pos = m_active.size();
      m_where[s] = W_ACTIVE;
      if (m_active.size() == 0) begin
         m_delta[s] = m_period[s];
         m_active.push_back(s);
         m_head = m_period[s];
         return;
      end
      m_delta[m_active[0]] = m_head;
      for (int i = 0; i < m_active.size(); i++) begin
         total += m_delta[m_active[i]];
         if (total > {32'd0, m_period[s]}) begin
            pos = i;
            break;
         end
      end
      if (pos < m_active.size()) begin
         total -= m_delta[m_active[pos]];
         m_delta[s] = m_period[s] - total[31:0];
         m_delta[m_active[pos]] -= m_delta[s];
         m_active.insert(pos, s);
      end else begin
         m_delta[s] = m_period[s] - total[31:0];
         m_active.push_back(s);
      end
      m_head = m_delta[m_active[0]];
   endfunction

   function automatic void push_rsp(status_type st, logic [KEY_W-1:0] k, logic v, logic l);
      response_t r;
      r.status = st; r.fired_key = k; r.fired_valid = v; r.last = l;
      expected_rsps.push_back(r);
   endfunction

   // work out the responses of one accepted request
   function automatic void predict_pool(request_t q);
      status_type st;
      int s, n;
      st = ST_OK;
      case (q.mode)
         MODE_CREATE: begin
            s = -1;
            if (q.period == 0) st = ST_BAD_ARG;
            else begin
               for (int i = 0; i < NSLOT; i++)
                  if (m_where[i] != W_IDLE && m_key[i] == q.key) st = ST_EXISTS;
               if (st == ST_OK) begin
                  for (int i = NSLOT - 1; i >= 0; i--)
                     if (m_where[i] == W_IDLE) s = i;
                  if (s < 0) st = ST_FULL;
                  else begin
                     m_key[s] = q.key; m_rep[s] = q.rep; m_period[s] = q.period;
                     arm_slot(s);
                  end
               end
            end
         end
         MODE_DESTROY: begin
            st = ST_NOT_FOUND;
            for (int i = 0; i < m_ready.size(); i++)
               if (m_key[m_ready[i]] == q.key) begin
                  s = m_ready[i];
                  m_ready.delete(i);
                  free_slot(s);
                  st = ST_OK;
                  break;
               end
            if (st != ST_OK)
               for (int i = 0; i < m_active.size(); i++)
                  if (m_key[m_active[i]] == q.key) begin
                     s = m_active[i];
                     m_delta[m_active[0]] = m_head;
                     if (i + 1 < m_active.size())
                        m_delta[m_active[i + 1]] += m_delta[s];
                     m_active.delete(i);
                     free_slot(s);
                     m_head = m_active.size() ? m_delta[m_active[0]] : '0;
                     st = ST_OK;
                     break;
                  end
         end
         MODE_TICK: begin
            m_head = m_head - 1;
            if (m_head == 0 && m_active.size() != 0) begin
               m_delta[m_active[0]] = '0;
               while (m_active.size() != 0 && m_delta[m_active[0]] == 0) begin
                  s = m_active.pop_front();
                  m_where[s] = W_READY;
                  if (m_ready.size() < NSLOT) m_ready.push_back(s);
               end
               if (m_active.size()) m_head = m_delta[m_active[0]];
            end
         end
         MODE_POLL: begin
            if (m_ready.size() != 0) begin
               n = 0;
               while (m_ready.size() != 0 && n < MAX_OUT) begin
                  s = m_ready.pop_front();
                  n++;
                  push_rsp(ST_OK, m_key[s], 1'b1, 1'b0);
                  if (m_rep[s]) arm_slot(s);
                  else free_slot(s);
               end
               expected_rsps[$].last = 1'b1;
               return;
            end
         end
         MODE_CLEAR: pool_reset();
         default: st = ST_BAD_ARG;
      endcase
      push_rsp(st, '0, 1'b0, 1'b1);
   endfunction

   task automatic report_mismatch(string what, response_t got, response_t exp);
      $display("mismatch (%s): got st=%0d key=%h v=%b l=%b, exp st=%0d key=%h v=%b l=%b",
               what, got.status, got.fired_key, got.fired_valid, got.last,
               exp.status, exp.fired_key, exp.fired_valid, exp.last);
      errors++;
   endtask

   function automatic void add_req(logic [2:0] m, logic [15:0] k, logic [31:0] p, logic r);
      request_t q;
      q.mode = m; q.key = k; q.period = p; q.rep = r;
      pending_reqs.push_back(q);
   endfunction

   // driver: bursts of requests with random gaps
   int burst_left, gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.mode <= '0; req_chan.key <= '0;
         req_chan.period <= '0; req_chan.repeat_req <= 1'b0;
         burst_left <= 0; gap_left <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            predict_pool({req_chan.mode, req_chan.key, req_chan.period,
                          req_chan.repeat_req});
            n_sent <= n_sent + 1;
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            request_t q;
            q = pending_reqs.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.mode <= q.mode; req_chan.key <= q.key;
            req_chan.period <= q.period; req_chan.repeat_req <= q.rep;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 20);
            end else burst_left <= burst_left - 1;
         end else req_chan.valid <= 1'b0;
      end
   end

   // receiver stall pattern with one long hold-off
   int hold_cycles, stall_phase;
   logic hold_on = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_phase <= 0;
      end else if (hold_on) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 400) hold_on <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 37;
         rsp_chan.ready <= (stall_phase < 20) ? 1'b1 : ($urandom_range(0, 2) != 0);
         if (n_sent == 120 && hold_cycles == 0) begin
            hold_on <= 1'b1;
            hold_cycles <= 1;
         end
      end
   end

   // monitor: compare each response with the oldest expectation
   int idle_cycles;
   always @(posedge clock) begin
      if (reset) idle_cycles <= 0;
      else begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_chan.valid && rsp_chan.ready) begin
            response_t got, exp;
            got = {rsp_chan.status, rsp_chan.fired_key, rsp_chan.fired_valid,
                   rsp_chan.last};
            n_rsp <= n_rsp + 1;
            if (expected_rsps.size() == 0) report_mismatch("unexpected", got, got);
            else begin
               exp = expected_rsps.pop_front();
               if (got !== exp) report_mismatch("fields", got, exp);
               if (got.fired_valid) n_fired <= n_fired + 1;
               n_stat[exp.status] <= n_stat[exp.status] + 1;
            end
         end
         if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired, %0d responses outstanding", expected_rsps.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] k;
      int r;
      errors = 0; n_sent = 0; n_rsp = 0; n_fired = 0; hold_cycles = 0;
      for (int i = 0; i < 8; i++) n_stat[i] = 0;
      pool_reset();
      req_chan.valid = 1'b0; req_chan.mode = '0; req_chan.key = '0;
      req_chan.period = '0; req_chan.repeat_req = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: edge fields, every operation and error path
      add_req(MODE_POLL, 0, 0, 0);
      add_req(MODE_CREATE, 16'h1, 0, 0);
      add_req(MODE_CREATE, 16'hffff, 32'hffffffff, 1);
      add_req(MODE_CREATE, 16'h0, 1, 1);
      add_req(MODE_CREATE, 16'h0, 5, 0);
      add_req(MODE_CREATE, 16'h5, 1, 0);
      add_req(MODE_CREATE, 16'h6, 3, 0);
      add_req(MODE_TICK, 0, 0, 0);
      add_req(MODE_POLL, 0, 0, 0);
      add_req(MODE_DESTROY, 16'h1234, 0, 0);
      add_req(MODE_DESTROY, 16'h6, 0, 0);
      add_req(MODE_TICK, 0, 0, 0);
      add_req(MODE_DESTROY, 16'h0, 0, 0);
      add_req(3'd5, 16'haaaa, 32'h55555555, 1);
      add_req(3'd7, 0, 0, 0);
      add_req(MODE_CLEAR, 0, 0, 0);
      add_req(MODE_TICK, 0, 0, 0);
      add_req(MODE_TICK, 0, 0, 0);
      // fill the pool, then overflow it
      for (int i = 0; i < NSLOT; i++)
         add_req(MODE_CREATE, 16'(16'h100 + i), 32'(1 + i % 2), 1'(i % 2));
      add_req(MODE_CREATE, 16'h200, 1, 0);
      add_req(MODE_TICK, 0, 0, 0);
      add_req(MODE_TICK, 0, 0, 0);
      add_req(MODE_POLL, 0, 0, 0);
      add_req(MODE_POLL, 0, 0, 0);

      // random: mostly small keys and short periods so timers fire
      for (int i = 0; i < 160; i++) begin
         r = $urandom_range(0, 99);
         k = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
         if (r < 35)
            add_req(MODE_CREATE, k,
                    ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 6),
                    1'($urandom));
         else if (r < 50) add_req(MODE_DESTROY, k, $urandom, 1'($urandom));
         else if (r < 78) add_req(MODE_TICK, k, $urandom, 1'($urandom));
         else if (r < 96) add_req(MODE_POLL, k, $urandom, 1'($urandom));
         else if (r < 98) add_req(MODE_CLEAR, k, $urandom, 1'($urandom));
         else add_req(3'($urandom_range(5, 7)), k, $urandom, 1'($urandom));
      end
      add_req(MODE_POLL, 0, 0, 0);

      while (pending_reqs.size() != 0 || req_chan.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      $display("sent %0d requests, checked %0d responses, %0d expiries", n_sent, n_rsp,
               n_fired);
      $display("status counts ok=%0d bad=%0d exists=%0d full=%0d notfound=%0d",
               n_stat[0], n_stat[1], n_stat[2], n_stat[3], n_stat[4]);
      if (errors == 0 && expected_rsps.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
